// File: hdl/imq_pkg.sv
// Package with the types, constants and codes of the indexed max-heap priority queue.
`timescale 1ns / 1ps
package imq_pkg;
  localparam int HEAP_DEPTH = 16;
  localparam int ID_COUNT = 32;
  localparam int SLOT_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W = SLOT_W + 2;
  localparam int ID_W = 5;
  localparam int KEY_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CHANGE = 2'd2,
    OP_PEEK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_FULL = 3'd1,
    ST_EMPTY = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PK_RD,
    S_PK_CAP,
    S_EX_RD0,
    S_EX_RDL,
    S_EX_LAST,
    S_CH_RD,
    S_CH_CMP,
    S_CH_CMP2,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [ID_W-1:0] entry_id;
    logic signed [KEY_W-1:0] entry_key;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [ID_W-1:0] out_id;
    logic signed [KEY_W-1:0] out_key;
    logic [4:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic signed [KEY_W-1:0] key;
  } slot_t;
endpackage

// File: hdl/imq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module imq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// File: hdl/indexed_max_priority_queue.sv
// Top level of the indexed max-heap priority queue.
// The block holds up to 16 (id, key) entries in a binary max-heap kept in a
// small RAM, with a table from id to heap slot. One word is taken at a time;
// the block stalls its input until the request is finished. Insert, change
// key and extract walk the heap one level at a time, at a pace set by the
// single RAM read and write port and the one key comparator that every step
// shares. The next word may be taken while the previous result still waits
// at the output.
`timescale 1ns / 1ps
module indexed_max_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  imq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output imq_pkg::out_word_t out_word
);
  imq_pkg::state_t state_r, state_nxt;
  logic [imq_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [imq_pkg::SLOT_W-1:0] pos_r, pos_nxt;
  logic [imq_pkg::SLOT_W-1:0] bidx_r, bidx_nxt;
  logic best_cur_r, best_cur_nxt;
  imq_pkg::slot_t cur_r, cur_nxt;
  imq_pkg::slot_t best_r, best_nxt;
  logic signed [imq_pkg::KEY_W-1:0] old_r, old_nxt;
  logic [2:0] status_r, status_nxt;
  logic [imq_pkg::ID_W-1:0] oid_r, oid_nxt;
  logic signed [imq_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic out_valid_r, out_valid_nxt;
  imq_pkg::out_word_t out_word_r, out_word_nxt;
  logic [imq_pkg::ID_COUNT-1:0] present_r, present_nxt;

  logic sid_we;
  logic [imq_pkg::ID_W-1:0] sid_addr;
  logic [imq_pkg::SLOT_W-1:0] sid_val;
  logic [imq_pkg::ID_W-1:0] sid_raddr;
  logic [imq_pkg::SLOT_W-1:0] sid_rdata;
  logic ram_we;
  logic [imq_pkg::SLOT_W-1:0] ram_waddr, ram_raddr;
  imq_pkg::slot_t ram_wdata, ram_rdata;
  logic signed [imq_pkg::KEY_W-1:0] cmp_a, cmp_b;
  logic cmp_lt;
  logic [imq_pkg::CHILD_W-1:0] child_l, child_r, fill_ext;
  logic [imq_pkg::SLOT_W-1:0] parent;
  logic accept;

  imq_ram #(
    .WIDTH($bits(imq_pkg::slot_t)),
    .DEPTH(imq_pkg::HEAP_DEPTH)
  ) u_heap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  imq_ram #(
    .WIDTH(imq_pkg::SLOT_W),
    .DEPTH(imq_pkg::ID_COUNT)
  ) u_slot_of_id (
    .clk  (clk),
    .we   (sid_we),
    .waddr(sid_addr),
    .wdata(sid_val),
    .raddr(sid_raddr),
    .rdata(sid_rdata)
  );

  assign cmp_lt = cmp_a < cmp_b;
  assign child_l = {1'b0, pos_r, 1'b1};
  assign child_r = child_l + imq_pkg::CHILD_W'(1);
  assign fill_ext = imq_pkg::CHILD_W'(fill_r);
  assign parent = (pos_r - imq_pkg::SLOT_W'(1)) >> 1;
  assign in_stall = (state_r != imq_pkg::S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;
  assign sid_raddr = in_word.entry_id;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    pos_nxt = pos_r;
    bidx_nxt = bidx_r;
    best_cur_nxt = best_cur_r;
    cur_nxt = cur_r;
    best_nxt = best_r;
    old_nxt = old_r;
    status_nxt = status_r;
    oid_nxt = oid_r;
    okey_nxt = okey_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt = out_word_r;
    present_nxt = present_r;
    sid_we = 1'b0;
    sid_addr = cur_r.id;
    sid_val = pos_r;
    ram_we = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = cur_r;
    ram_raddr = '0;
    cmp_a = ram_rdata.key;
    cmp_b = cur_r.key;
    case (state_r)
      imq_pkg::S_IDLE: begin
        if (accept) begin
          status_nxt = imq_pkg::ST_OK;
          oid_nxt = '0;
          okey_nxt = '0;
          cur_nxt.id = in_word.entry_id;
          cur_nxt.key = in_word.entry_key;
          state_nxt = imq_pkg::S_DONE;
          case (imq_pkg::op_t'(in_word.operation))
            imq_pkg::OP_INSERT: begin
              if (fill_r == imq_pkg::CNT_W'(imq_pkg::HEAP_DEPTH)) begin
                status_nxt = imq_pkg::ST_FULL;
              end else if (present_r[in_word.entry_id]) begin
                status_nxt = imq_pkg::ST_DUP;
              end else begin
                pos_nxt = fill_r[imq_pkg::SLOT_W-1:0];
                fill_nxt = fill_r + imq_pkg::CNT_W'(1);
                present_nxt[in_word.entry_id] = 1'b1;
                state_nxt = imq_pkg::S_UP_RD;
              end
            end
            imq_pkg::OP_EXTRACT: begin
              if (fill_r == '0) begin
                status_nxt = imq_pkg::ST_EMPTY;
              end else begin
                state_nxt = imq_pkg::S_EX_RD0;
              end
            end
            imq_pkg::OP_CHANGE: begin
              if (!present_r[in_word.entry_id]) begin
                status_nxt = imq_pkg::ST_ABSENT;
              end else begin
                state_nxt = imq_pkg::S_CH_RD;
              end
            end
            default: begin
              if (fill_r == '0) begin
                status_nxt = imq_pkg::ST_EMPTY;
              end else begin
                state_nxt = imq_pkg::S_PK_RD;
              end
            end
          endcase
        end
      end
      imq_pkg::S_PK_RD: begin
        ram_raddr = '0;
        state_nxt = imq_pkg::S_PK_CAP;
      end
      imq_pkg::S_PK_CAP: begin
        oid_nxt = ram_rdata.id;
        okey_nxt = ram_rdata.key;
        state_nxt = imq_pkg::S_DONE;
      end
      imq_pkg::S_EX_RD0: begin
        ram_raddr = '0;
        state_nxt = imq_pkg::S_EX_RDL;
      end
      imq_pkg::S_EX_RDL: begin
        oid_nxt = ram_rdata.id;
        okey_nxt = ram_rdata.key;
        present_nxt[ram_rdata.id] = 1'b0;
        ram_raddr = imq_pkg::SLOT_W'(fill_r - imq_pkg::CNT_W'(1));
        fill_nxt = fill_r - imq_pkg::CNT_W'(1);
        state_nxt = imq_pkg::S_EX_LAST;
      end
      imq_pkg::S_EX_LAST: begin
        cur_nxt = ram_rdata;
        pos_nxt = '0;
        state_nxt = imq_pkg::S_DN_RDL;
      end
      imq_pkg::S_CH_RD: begin
        ram_raddr = sid_rdata;
        pos_nxt = sid_rdata;
        state_nxt = imq_pkg::S_CH_CMP;
      end
      imq_pkg::S_CH_CMP: begin
        old_nxt = ram_rdata.key;
        state_nxt = cmp_lt ? imq_pkg::S_UP_RD : imq_pkg::S_CH_CMP2;
      end
      imq_pkg::S_CH_CMP2: begin
        cmp_a = cur_r.key;
        cmp_b = old_r;
        state_nxt = cmp_lt ? imq_pkg::S_DN_RDL : imq_pkg::S_DONE;
      end
      imq_pkg::S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we = 1'b1;
          sid_we = 1'b1;
          state_nxt = imq_pkg::S_DONE;
        end else begin
          ram_raddr = parent;
          state_nxt = imq_pkg::S_UP_CMP;
        end
      end
      imq_pkg::S_UP_CMP: begin
        ram_we = 1'b1;
        sid_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
          sid_addr = ram_rdata.id;
          pos_nxt = parent;
          state_nxt = imq_pkg::S_UP_RD;
        end else begin
          state_nxt = imq_pkg::S_DONE;
        end
      end
      imq_pkg::S_DN_RDL: begin
        if (child_l >= fill_ext) begin
          ram_we = 1'b1;
          sid_we = 1'b1;
          state_nxt = imq_pkg::S_DONE;
        end else begin
          ram_raddr = child_l[imq_pkg::SLOT_W-1:0];
          state_nxt = imq_pkg::S_DN_RDR;
        end
      end
      imq_pkg::S_DN_RDR: begin
        cmp_a = cur_r.key;
        cmp_b = ram_rdata.key;
        best_cur_nxt = !cmp_lt;
        best_nxt = cmp_lt ? ram_rdata : cur_r;
        bidx_nxt = child_l[imq_pkg::SLOT_W-1:0];
        if (child_r < fill_ext) begin
          ram_raddr = child_r[imq_pkg::SLOT_W-1:0];
          state_nxt = imq_pkg::S_DN_CMP;
        end else begin
          state_nxt = imq_pkg::S_DN_MOVE;
        end
      end
      imq_pkg::S_DN_CMP: begin
        cmp_a = best_r.key;
        cmp_b = ram_rdata.key;
        if (cmp_lt) begin
          best_nxt = ram_rdata;
          best_cur_nxt = 1'b0;
          bidx_nxt = child_r[imq_pkg::SLOT_W-1:0];
        end
        state_nxt = imq_pkg::S_DN_MOVE;
      end
      imq_pkg::S_DN_MOVE: begin
        ram_we = 1'b1;
        sid_we = 1'b1;
        if (best_cur_r) begin
          state_nxt = imq_pkg::S_DONE;
        end else begin
          ram_wdata = best_r;
          sid_addr = best_r.id;
          pos_nxt = bidx_r;
          state_nxt = imq_pkg::S_DN_RDL;
        end
      end
      imq_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt.status = status_r;
          out_word_nxt.out_id = oid_r;
          out_word_nxt.out_key = okey_r;
          out_word_nxt.entry_count = 5'(fill_r);
          state_nxt = imq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = imq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imq_pkg::S_IDLE;
      fill_r <= '0;
      present_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      present_r <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    bidx_r <= bidx_nxt;
    best_cur_r <= best_cur_nxt;
    cur_r <= cur_nxt;
    best_r <= best_nxt;
    old_r <= old_nxt;
    status_r <= status_nxt;
    oid_r <= oid_nxt;
    okey_r <= okey_nxt;
    out_word_r <= out_word_nxt;
  end
endmodule

// File: hdl/imq_checker.sv
// Port checker for the indexed max-heap priority queue, bound to the top level.
`timescale 1ns / 1ps
module imq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input imq_pkg::out_word_t out_word
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("Stalled output word changed.");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.entry_count <= 5'(imq_pkg::HEAP_DEPTH))
    else $error("Entry count exceeds heap depth.");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == imq_pkg::ST_FULL |->
      out_word.entry_count == 5'(imq_pkg::HEAP_DEPTH))
    else $error("Full status with a heap that is not full.");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == imq_pkg::ST_EMPTY |->
      out_word.entry_count == '0 && out_word.out_id == '0 && out_word.out_key == '0)
    else $error("Empty status with entries or a nonzero top.");
endmodule

bind indexed_max_priority_queue imq_checker u_imq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);

// File: tb/sv/tb.sv
// Testbench for the indexed max-heap priority queue: directed table, random traffic, heap model.
`timescale 1ns / 1ps
module tb;
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  imq_pkg::in_word_t in_word;
  logic out_valid;
  logic out_stall;
  imq_pkg::out_word_t out_word;

  indexed_max_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  typedef struct {
    imq_pkg::in_word_t word;
    logic typed;
    imq_pkg::out_word_t answer;
  } row_t;

  imq_pkg::slot_t heap_mem [imq_pkg::HEAP_DEPTH];
  int slot_of [imq_pkg::ID_COUNT];
  bit held [imq_pkg::ID_COUNT];
  int fill;
  imq_pkg::out_word_t pending_results [$];
  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int quiet_cycles;
  row_t rows [$];
  logic exp_typed;
  imq_pkg::out_word_t exp_answer;

  function automatic void swap_slots(int a, int b);
    imq_pkg::slot_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
    slot_of[heap_mem[a].id] = a;
    slot_of[heap_mem[b].id] = b;
  endfunction

  function automatic void sift_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(heap_mem[p].key < heap_mem[i].key)) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sift_down(int i);
    int l;
    int r;
    int big;
    while (i < fill) begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      big = i;
      if (l < fill && heap_mem[big].key < heap_mem[l].key) big = l;
      if (r < fill && heap_mem[big].key < heap_mem[r].key) big = r;
      if (big == i) break;
      swap_slots(i, big);
      i = big;
    end
  endfunction

  function automatic imq_pkg::out_word_t heap_apply(imq_pkg::in_word_t w);
    imq_pkg::out_word_t res;
    int s;
    logic signed [imq_pkg::KEY_W-1:0] old;
    res = '0;
    res.status = imq_pkg::ST_OK;
    case (imq_pkg::op_t'(w.operation))
      imq_pkg::OP_INSERT: begin
        if (fill >= imq_pkg::HEAP_DEPTH) res.status = imq_pkg::ST_FULL;
        else if (held[w.entry_id]) res.status = imq_pkg::ST_DUP;
        else begin
          heap_mem[fill].id = w.entry_id;
          heap_mem[fill].key = w.entry_key;
          slot_of[w.entry_id] = fill;
          held[w.entry_id] = 1'b1;
          fill++;
          sift_up(fill - 1);
        end
      end
      imq_pkg::OP_EXTRACT: begin
        if (fill == 0) res.status = imq_pkg::ST_EMPTY;
        else begin
          res.out_id = heap_mem[0].id;
          res.out_key = heap_mem[0].key;
          held[heap_mem[0].id] = 1'b0;
          heap_mem[0] = heap_mem[fill - 1];
          slot_of[heap_mem[0].id] = 0;
          fill--;
          sift_down(0);
        end
      end
      imq_pkg::OP_CHANGE: begin
        if (!held[w.entry_id]) res.status = imq_pkg::ST_ABSENT;
        else begin
          s = slot_of[w.entry_id];
          old = heap_mem[s].key;
          heap_mem[s].key = w.entry_key;
          if (old < w.entry_key) sift_up(s);
          else if (w.entry_key < old) sift_down(s);
        end
      end
      default: begin
        if (fill == 0) res.status = imq_pkg::ST_EMPTY;
        else begin
          res.out_id = heap_mem[0].id;
          res.out_key = heap_mem[0].key;
        end
      end
    endcase
    res.entry_count = fill[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch %s got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic imq_pkg::in_word_t make_word(imq_pkg::op_t op, int id, logic [31:0] key);
    imq_pkg::in_word_t w;
    w.operation = op;
    w.entry_id = id[4:0];
    w.entry_key = key;
    return w;
  endfunction

  function automatic imq_pkg::out_word_t make_answer(imq_pkg::status_t st, int id,
                                                     logic [31:0] key, int cnt);
    imq_pkg::out_word_t a;
    a.status = st;
    a.out_id = id[4:0];
    a.out_key = key;
    a.entry_count = cnt[4:0];
    return a;
  endfunction

  task automatic add_row(imq_pkg::op_t op, int id, logic [31:0] key, bit typed = 0,
                         imq_pkg::status_t st = imq_pkg::ST_OK, int oid = 0,
                         logic [31:0] okey = 0, int cnt = 0);
    row_t r;
    r.word = make_word(op, id, key);
    r.typed = typed;
    r.answer = make_answer(st, oid, okey, cnt);
    rows.push_back(r);
  endtask

  task automatic send_word(imq_pkg::in_word_t w, logic typed, imq_pkg::out_word_t answer);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    exp_typed <= typed;
    exp_answer <= answer;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic imq_pkg::in_word_t random_word();
    int pick;
    int id;
    pick = $urandom_range(99);
    id = $urandom_range(31);
    if (pick < 5) id = $urandom_range(3);
    if (pick < 40) return make_word(imq_pkg::OP_INSERT, id, $urandom);
    if (pick < 65) return make_word(imq_pkg::OP_EXTRACT, id, $urandom);
    if (pick < 90) begin
      if (fill > 0 && $urandom_range(3) != 0) id = heap_mem[$urandom_range(fill - 1)].id;
      if ($urandom_range(9) == 0) return make_word(imq_pkg::OP_CHANGE, id, heap_mem[0].key);
      return make_word(imq_pkg::OP_CHANGE, id, $urandom);
    end
    return make_word(imq_pkg::OP_PEEK, id, $urandom);
  endfunction

  always @(posedge clk) begin
    imq_pkg::out_word_t pred;
    imq_pkg::out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = heap_apply(in_word);
        if (exp_typed) pred = exp_answer;
        pending_results.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_word), 64'(0));
        end else begin
          want = pending_results.pop_front();
          if (out_word.status !== want.status)
            report_mismatch("status", 64'(out_word.status), 64'(want.status));
          if (out_word.out_id !== want.out_id)
            report_mismatch("out_id", 64'(out_word.out_id), 64'(want.out_id));
          if (out_word.out_key !== want.out_key)
            report_mismatch("out_key", 64'(out_word.out_key), 64'(want.out_key));
          if (out_word.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(out_word.entry_count),
                            64'(want.entry_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_stall <= hold_off;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    row_t r;
    in_valid = 1'b0;
    in_word = '0;
    exp_typed = 1'b0;
    exp_answer = '0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    fill = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (held[i]) held[i] = 1'b0;
    foreach (slot_of[i]) slot_of[i] = 0;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_row(imq_pkg::OP_PEEK, 0, 0, 1, imq_pkg::ST_EMPTY, 0, 0, 0);
    add_row(imq_pkg::OP_EXTRACT, 31, 32'hFFFFFFFF, 1, imq_pkg::ST_EMPTY, 0, 0, 0);
    add_row(imq_pkg::OP_CHANGE, 5, 1, 1, imq_pkg::ST_ABSENT, 0, 0, 0);
    add_row(imq_pkg::OP_INSERT, 0, 32'h80000000, 1, imq_pkg::ST_OK, 0, 0, 1);
    add_row(imq_pkg::OP_INSERT, 0, 7, 1, imq_pkg::ST_DUP, 0, 0, 1);
    add_row(imq_pkg::OP_PEEK, 0, 0, 1, imq_pkg::ST_OK, 0, 32'h80000000, 1);
    add_row(imq_pkg::OP_INSERT, 31, 32'h7FFFFFFF, 1, imq_pkg::ST_OK, 0, 0, 2);
    add_row(imq_pkg::OP_PEEK, 0, 0, 1, imq_pkg::ST_OK, 31, 32'h7FFFFFFF, 2);
    for (int i = 1; i <= 14; i++) add_row(imq_pkg::OP_INSERT, i, (i % 4) * 3 - 5);
    add_row(imq_pkg::OP_INSERT, 20, 0, 1, imq_pkg::ST_FULL, 0, 0, 16);
    add_row(imq_pkg::OP_CHANGE, 3, 32'h7FFFFFFF);
    add_row(imq_pkg::OP_CHANGE, 31, 32'h80000000);
    add_row(imq_pkg::OP_CHANGE, 7, 1);
    add_row(imq_pkg::OP_EXTRACT, 0, 0);
    add_row(imq_pkg::OP_EXTRACT, 0, 0);
    foreach (rows[i]) begin
      r = rows[i];
      send_word(r.word, r.typed, r.answer);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 80; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 80; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (phase == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 375; n++) send_word(random_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
